// File: hw/rtl/bdc_pkg.sv
package bdc_pkg;

    // Button identities as emitted on the result channel
    localparam logic [1:0] BTN_BACK   = 2'd0;
    localparam logic [1:0] BTN_UP     = 2'd1;
    localparam logic [1:0] BTN_SELECT = 2'd2;
    localparam logic [1:0] BTN_DOWN   = 2'd3;

    // Pending slot code for "nothing pending"
    localparam logic [2:0] NO_PENDING = 3'd4;

    // Result kinds
    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_BOOT   = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] REG_GRACE       = 3'd1;
    localparam logic [2:0] REG_HOLD        = 3'd2;
    localparam logic [2:0] REG_COMBO       = 3'd3;
    localparam logic [2:0] REG_ROTATED     = 3'd4;
    localparam logic [2:0] REG_PRESENT     = 3'd5;
    localparam logic [2:0] REG_ACTIVE_HIGH = 3'd6;

    // Most events one poll tick can raise
    localparam int MAX_EVENTS = 5;

    typedef struct packed {
        logic [15:0] debounce_samples;
        logic [15:0] grace_samples;
        logic [15:0] hold_samples;
        logic [2:0]  combo_mask;
        logic        rotated;
        logic [2:0]  present_mask;
        logic [2:0]  active_high_mask;
    } cfg_t;

    typedef struct packed {
        logic [2:0]       debounced;
        logic [3:0]       emitted;
        logic [2:0]       pending_id;
        logic [15:0]      pending_count;
        logic [2:0]       suppress;
        logic [2:0][15:0] debounce_count;
        logic [15:0]      hold_count;
    } state_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] button;
        logic       pressed;
    } event_t;

    typedef struct packed {
        event_t [MAX_EVENTS-1:0] ev;
        logic [2:0]              n;
    } ev_list_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] button;
        logic       pressed;
        logic       last;
    } out_beat_t;

    localparam cfg_t CFG_RESET = '{
        debounce_samples: 16'd3,
        grace_samples:    16'd5,
        hold_samples:     16'd100,
        combo_mask:       3'd6,
        rotated:          1'b0,
        present_mask:     3'd7,
        active_high_mask: 3'd0
    };

    localparam state_t STATE_RESET = '{
        debounced:      3'd0,
        emitted:        4'd0,
        pending_id:     NO_PENDING,
        pending_count:  16'd0,
        suppress:       3'd0,
        debounce_count: '0,
        hold_count:     16'd0
    };

endpackage

// File: hw/rtl/button_debounce_combo_synth_core.sv
// Button debounce and combo synthesizer. Each beat on the s_ channel is one
// poll tick of the back/up/select pins; the block returns zero to five result
// beats on the m_ channel, the final one of a tick flagged by m_last. The
// whole tick is evaluated combinationally on acceptance and its events are parked
// in a five-entry batch buffer that drains through the output register at one
// beat per cycle while m_ready keeps the output register free. A tick that
// raises events keeps s_ready low until all of them have reached the output
// register, while ticks that raise none go back to back. The
// next tick is taken in the cycle after the last event of the previous one has
// moved into the output register, so it overlaps the final beat waiting on
// m_ready. Configuration writes take effect on the next tick and must be made
// while no results are outstanding.
module button_debounce_combo_synth_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_pin_levels,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [1:0]  m_button,
    output logic        m_pressed,
    output logic        m_last
);

    bdc_pkg::cfg_t      cfg_reg;
    bdc_pkg::state_t    state_reg;
    bdc_pkg::state_t    state_next;
    bdc_pkg::ev_list_t  events;
    logic               all_pressed;

    bdc_pkg::out_beat_t batch_reg [bdc_pkg::MAX_EVENTS];
    logic [2:0]         batch_cnt_reg;
    bdc_pkg::out_beat_t out_reg;
    logic               out_valid_reg;

    logic               accept;
    logic               out_load;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= bdc_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bdc_pkg::REG_DEBOUNCE:    cfg_reg.debounce_samples <= cfg_wdata;
                bdc_pkg::REG_GRACE:       cfg_reg.grace_samples    <= cfg_wdata;
                bdc_pkg::REG_HOLD:        cfg_reg.hold_samples     <= cfg_wdata;
                bdc_pkg::REG_COMBO:       cfg_reg.combo_mask       <= cfg_wdata[2:0];
                bdc_pkg::REG_ROTATED:     cfg_reg.rotated          <= cfg_wdata[0];
                bdc_pkg::REG_PRESENT:     cfg_reg.present_mask     <= cfg_wdata[2:0];
                bdc_pkg::REG_ACTIVE_HIGH: cfg_reg.active_high_mask <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    bdc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .pin_levels (s_pin_levels),
        .state_next (state_next),
        .events     (events),
        .all_pressed(all_pressed)
    );

    assign s_ready  = (batch_cnt_reg == 3'd0);
    assign accept   = s_valid && s_ready;
    assign out_load = (batch_cnt_reg != 3'd0) && (!out_valid_reg || m_ready);

    // Advance the tick state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bdc_pkg::STATE_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Batch buffer: load a tick's events, shift one out per output load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_cnt_reg <= 3'd0;
        end else if (accept) begin
            batch_cnt_reg <= events.n;
        end else if (out_load) begin
            batch_cnt_reg <= batch_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < bdc_pkg::MAX_EVENTS; i++) begin
                batch_reg[i].kind    <= events.ev[i].kind;
                batch_reg[i].button  <= events.ev[i].button;
                batch_reg[i].pressed <= events.ev[i].pressed;
                batch_reg[i].last    <= (3'(i) + 3'd1 == events.n);
            end
        end else if (out_load) begin
            for (int i = 0; i < bdc_pkg::MAX_EVENTS - 1; i++) begin
                batch_reg[i] <= batch_reg[i+1];
            end
        end
    end

    // Output register: hold until taken, refill from the batch head
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= batch_reg[0];
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_kind    = out_reg.kind;
    assign m_button  = out_reg.button;
    assign m_pressed = out_reg.pressed;
    assign m_last    = out_reg.last;

    // Batch never holds more events than one tick can raise
    assert property (@(posedge aclk) disable iff (!aresetn)
        batch_cnt_reg <= 3'(bdc_pkg::MAX_EVENTS))
        else $error("batch count above event limit");

    // Only up or select can sit in the pending slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pending_id == bdc_pkg::NO_PENDING ||
        state_reg.pending_id == {1'b0, bdc_pkg::BTN_UP} ||
        state_reg.pending_id == {1'b0, bdc_pkg::BTN_SELECT})
        else $error("illegal pending button");

    // A boot request always closes its tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == bdc_pkg::KIND_BOOT |-> m_last)
        else $error("boot request not last of tick");

    // Holding all three buttons releases every emitted button
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && all_pressed |=> state_reg.emitted == 4'd0)
        else $error("buttons still emitted while all held");

endmodule

// File: hw/rtl/bdc_step.sv
// Per-tick update: debounce, combo, grace and hold logic for one poll tick.
// Produces the next state and the ordered list of events of the tick.
module bdc_step (
    input  bdc_pkg::cfg_t     cfg,
    input  bdc_pkg::state_t   state,
    input  logic [2:0]        pin_levels,
    output bdc_pkg::state_t   state_next,
    output bdc_pkg::ev_list_t events,
    output logic              all_pressed
);

    typedef struct packed {
        logic [3:0]        emitted;
        bdc_pkg::ev_list_t list;
    } emit_ctx_t;

    emit_ctx_t        ctx;
    bdc_pkg::state_t  nx;
    logic [2:0]       raw;
    logic [1:0]       bt;
    logic             pend_hit;

    // Map a logical button to its emitted identity
    function automatic logic [1:0] rot_id(logic rot, logic [1:0] id);
        logic [1:0] r;
        r = id;
        if (rot && id == bdc_pkg::BTN_UP) begin
            r = bdc_pkg::BTN_DOWN;
        end else if (rot && id == bdc_pkg::BTN_DOWN) begin
            r = bdc_pkg::BTN_UP;
        end
        return r;
    endfunction

    function automatic logic is_emit(logic [3:0] emitted, logic rot, logic [1:0] id);
        return emitted[rot_id(rot, id)];
    endfunction

    // Append one event, capped at the list depth
    function automatic bdc_pkg::ev_list_t push(bdc_pkg::ev_list_t l, logic kind,
                                               logic [1:0] btn, logic prs);
        bdc_pkg::ev_list_t r;
        r = l;
        if (l.n < 3'(bdc_pkg::MAX_EVENTS)) begin
            r.ev[l.n].kind    = kind;
            r.ev[l.n].button  = btn;
            r.ev[l.n].pressed = prs;
            r.n               = l.n + 3'd1;
        end
        return r;
    endfunction

    // Change an emitted state bit and log the edge if it moved
    function automatic emit_ctx_t set_emit(emit_ctx_t c, logic rot, logic [1:0] id,
                                           logic on);
        emit_ctx_t  r;
        logic [1:0] e;
        r = c;
        e = rot_id(rot, id);
        if (c.emitted[e] != on) begin
            r.emitted[e] = on;
            r.list       = push(c.list, bdc_pkg::KIND_BUTTON, e, on);
        end
        return r;
    endfunction

    always_comb begin
        nx          = state;
        ctx.emitted = state.emitted;
        ctx.list    = '0;
        bt          = bdc_pkg::BTN_UP;
        pend_hit    = 1'b0;
        raw         = ~(pin_levels ^ cfg.active_high_mask) & cfg.present_mask;

        if (raw == 3'b111) begin
            // All three held: silence everything and count toward boot request
            if (state.hold_count < cfg.hold_samples) begin
                nx.hold_count = state.hold_count + 16'd1;
            end
            nx.debounce_count = '0;
            ctx = set_emit(ctx, cfg.rotated, bdc_pkg::BTN_BACK, 1'b0);
            nx.pending_id    = bdc_pkg::NO_PENDING;
            nx.pending_count = '0;
            ctx = set_emit(ctx, cfg.rotated, bdc_pkg::BTN_UP, 1'b0);
            ctx = set_emit(ctx, cfg.rotated, bdc_pkg::BTN_SELECT, 1'b0);
            ctx = set_emit(ctx, cfg.rotated, bdc_pkg::BTN_DOWN, 1'b0);
            nx.suppress = state.debounced & cfg.combo_mask;
            if (nx.hold_count >= cfg.hold_samples) begin
                ctx.list = push(ctx.list, bdc_pkg::KIND_BOOT, bdc_pkg::BTN_BACK, 1'b0);
            end
        end else begin
            nx.hold_count = '0;

            // Debounce each pin independently
            for (int i = 0; i < 3; i++) begin
                if (raw[i] == state.debounced[i]) begin
                    nx.debounce_count[i] = '0;
                end else begin
                    nx.debounce_count[i] = state.debounce_count[i] + 16'd1;
                    if (nx.debounce_count[i] >= cfg.debounce_samples) begin
                        nx.debounce_count[i] = '0;
                        nx.debounced[i]      = raw[i];
                    end
                end
            end

            ctx = set_emit(ctx, cfg.rotated, bdc_pkg::BTN_BACK, nx.debounced[0]);

            if ((nx.debounced & cfg.combo_mask) == cfg.combo_mask) begin
                // Combo held: synthetic down replaces up and select
                nx.pending_id    = bdc_pkg::NO_PENDING;
                nx.pending_count = '0;
                ctx = set_emit(ctx, cfg.rotated, bdc_pkg::BTN_UP, 1'b0);
                ctx = set_emit(ctx, cfg.rotated, bdc_pkg::BTN_SELECT, 1'b0);
                ctx = set_emit(ctx, cfg.rotated, bdc_pkg::BTN_DOWN, 1'b1);
            end else begin
                // Combo broken: release down, mask partners until they let go
                if (is_emit(ctx.emitted, cfg.rotated, bdc_pkg::BTN_DOWN)) begin
                    ctx = set_emit(ctx, cfg.rotated, bdc_pkg::BTN_DOWN, 1'b0);
                    nx.suppress = nx.suppress | (nx.debounced & cfg.combo_mask);
                end

                // Navigation update for up, then select
                for (int b = 1; b <= 2; b++) begin
                    bt       = 2'(b);
                    pend_hit = (nx.pending_id == {1'b0, bt});
                    if (nx.suppress[b]) begin
                        if (!nx.debounced[b]) begin
                            nx.suppress[b] = 1'b0;
                        end
                        if (pend_hit) begin
                            nx.pending_id    = bdc_pkg::NO_PENDING;
                            nx.pending_count = '0;
                        end
                        ctx = set_emit(ctx, cfg.rotated, bt, 1'b0);
                    end else if (nx.debounced[b]) begin
                        if (!is_emit(ctx.emitted, cfg.rotated, bt)) begin
                            if (nx.pending_id == bdc_pkg::NO_PENDING) begin
                                nx.pending_id    = {1'b0, bt};
                                nx.pending_count = '0;
                            end else if (pend_hit) begin
                                nx.pending_count = nx.pending_count + 16'd1;
                                if (nx.pending_count >= cfg.grace_samples) begin
                                    nx.pending_id    = bdc_pkg::NO_PENDING;
                                    nx.pending_count = '0;
                                    ctx = set_emit(ctx, cfg.rotated, bt, 1'b1);
                                end
                            end
                        end
                    end else begin
                        // Released during grace: emit a tap
                        if (pend_hit) begin
                            nx.pending_id    = bdc_pkg::NO_PENDING;
                            nx.pending_count = '0;
                            ctx = set_emit(ctx, cfg.rotated, bt, 1'b1);
                            ctx = set_emit(ctx, cfg.rotated, bt, 1'b0);
                        end
                        ctx = set_emit(ctx, cfg.rotated, bt, 1'b0);
                    end
                end
            end
        end

        nx.emitted = ctx.emitted;
    end

    assign state_next  = nx;
    assign events      = ctx.list;
    assign all_pressed = (raw == 3'b111);

endmodule
